### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the pending table RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of aclk, off while aresetn is low.
`define ACPT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge of aclk, reset included.
`define ACPT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/acpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpt_pkg
// Types and constants of the ACK coordination pending table.
// ----------------------------------------------------------------------------
package acpt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int COUNT_W         = 5;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_ACK   = 2'd1,
        CMD_SWEEP = 2'd2,
        CMD_DATA  = 2'd3
    } cmd_e_t;

    typedef enum logic [2:0] {
        ST_ADDED       = 3'd0,
        ST_REPLACED    = 3'd1,
        ST_FULL        = 3'd2,
        ST_ACK_MATCHED = 3'd3,
        ST_ACK_UNKNOWN = 3'd4,
        ST_SWEPT       = 3'd5,
        ST_ACK_SENT    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        MSG_NONE = 2'd0,
        MSG_ACK  = 2'd1,
        MSG_FWD  = 2'd2
    } msg_kind_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SCAN,
        SQ_DRAIN,
        SQ_COMMIT
    } seq_state_t;

    typedef struct packed {
        cmd_e_t      command;
        logic [31:0] pkt_id;
        logic [47:0] ack_sender;
        logic [31:0] deadline;
        logic [31:0] now_time;
    } item_t;

    typedef struct packed {
        status_t             status;
        msg_kind_t           msg_kind;
        logic [31:0]         msg_pkt_id;
        logic [47:0]         msg_destination;
        logic                msg_ttl;
        logic [COUNT_W-1:0]  expired_count;
    } result_t;

endpackage

### hdl/acpt_entry_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpt_entry_mem
// Entry store: {deadline, pkt_id} per slot, one write and one
// registered read port.
// ----------------------------------------------------------------------------
module acpt_entry_mem import acpt_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [63:0]                            wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [63:0]                            rd_data
);

    logic [63:0] mem [DEPTH];
    logic [63:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/acpt_cmp_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpt_cmp_unit
// Shared 32-bit compare: id match for add/ACK, deadline check for the sweep.
// ----------------------------------------------------------------------------
module acpt_cmp_unit (
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        eq,
    output logic        ge
);

    assign eq = (op_a == op_b);
    assign ge = (op_a >= op_b);

endmodule

### hdl/acpt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acpt_ctrl
// Sequencer: walks the table one slot per cycle (add, ACK, sweep) through the shared compare
// unit, holds the valid bits, commits the table update and builds the result.
// ----------------------------------------------------------------------------
module acpt_ctrl import acpt_pkg::*; #(
    parameter int DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  item_t       in_item,
    input  logic [47:0] local_address,
    input  logic        out_free,
    output logic        res_load,
    output result_t     res
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    seq_state_t state_reg, state_next;

    item_t              item_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic               cmp_pend_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [DEPTH-1:0]   valid_reg;

    logic        accept;
    logic        commit;
    logic        rd_en;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0] wr_data;
    logic [63:0] rd_data;
    logic [31:0] op_a;
    logic [31:0] op_b;
    logic        cmp_eq;
    logic        cmp_ge;
    logic        entry_ok;
    logic        is_sweep;

    acpt_entry_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    acpt_cmp_unit u_cmp (
        .op_a (op_a),
        .op_b (op_b),
        .eq   (cmp_eq),
        .ge   (cmp_ge)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE: begin
                if (in_valid) begin
                    state_next = (in_item.command == CMD_DATA) ? SQ_COMMIT : SQ_SCAN;
                end
            end
            SQ_SCAN: begin
                if (rd_idx_reg == IDX_LAST) begin
                    state_next = SQ_DRAIN;
                end
            end
            SQ_DRAIN: state_next = SQ_COMMIT;
            SQ_COMMIT: begin
                if (out_free) begin
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready = (state_reg == SQ_IDLE);
        rd_en    = (state_reg == SQ_SCAN);
        commit   = (state_reg == SQ_COMMIT) && out_free;
        res_load = commit;
    end

    assign accept   = in_valid && in_ready;
    assign is_sweep = (item_reg.command == CMD_SWEEP);
    assign op_a     = is_sweep ? item_reg.now_time : item_reg.pkt_id;
    assign op_b     = is_sweep ? rd_data[63:32] : rd_data[31:0];
    assign entry_ok = cmp_pend_reg && valid_reg[cmp_idx_reg];

    assign wr_en   = commit && (item_reg.command == CMD_ADD) && (found_reg || free_found_reg);
    assign wr_addr = found_reg ? hit_idx_reg : free_idx_reg;
    assign wr_data = {item_reg.deadline, item_reg.pkt_id};

    always_comb begin
        res = '0;
        case (item_reg.command)
            CMD_ADD: begin
                if (found_reg) begin
                    res.status = ST_REPLACED;
                end else if (free_found_reg) begin
                    res.status = ST_ADDED;
                end else begin
                    res.status = ST_FULL;
                end
            end
            CMD_ACK: begin
                if (found_reg) begin
                    res.status          = ST_ACK_MATCHED;
                    res.msg_kind        = MSG_FWD;
                    res.msg_pkt_id      = item_reg.pkt_id;
                    res.msg_destination = item_reg.ack_sender;
                    res.msg_ttl         = 1'b1;
                end else begin
                    res.status = ST_ACK_UNKNOWN;
                end
            end
            CMD_SWEEP: begin
                res.status        = ST_SWEPT;
                res.expired_count = count_reg;
            end
            default: begin
                res.status          = ST_ACK_SENT;
                res.msg_kind        = MSG_ACK;
                res.msg_pkt_id      = item_reg.pkt_id;
                res.msg_destination = local_address;
                res.msg_ttl         = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= SQ_IDLE;
            cmp_pend_reg   <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            valid_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                cmp_pend_reg   <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                count_reg      <= '0;
                rd_idx_reg     <= '0;
            end
            if (state_reg == SQ_SCAN) begin
                cmp_pend_reg <= 1'b1;
                if (rd_idx_reg != IDX_LAST) begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
            end
            if (state_reg == SQ_DRAIN) begin
                cmp_pend_reg <= 1'b0;
            end
            // compare stage, one slot behind the read
            if (cmp_pend_reg) begin
                if (is_sweep) begin
                    if (entry_ok && cmp_ge) begin
                        valid_reg[cmp_idx_reg] <= 1'b0;
                        if (count_reg != COUNT_MAX) begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end else begin
                    if (entry_ok && cmp_eq && !found_reg) begin
                        found_reg <= 1'b1;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                        free_found_reg <= 1'b1;
                    end
                end
            end
            if (commit) begin
                if (item_reg.command == CMD_ACK && found_reg) begin
                    valid_reg[hit_idx_reg] <= 1'b0;
                end
                if (item_reg.command == CMD_ADD && !found_reg && free_found_reg) begin
                    valid_reg[free_idx_reg] <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= in_item;
        end
        if (state_reg == SQ_SCAN) begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmp_pend_reg && !is_sweep) begin
            if (entry_ok && cmp_eq && !found_reg) begin
                hit_idx_reg <= cmp_idx_reg;
            end
            if (!valid_reg[cmp_idx_reg] && !free_found_reg) begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

endmodule

### hdl/ack_coordination_pending_table.sv
`timescale 1ns / 1ps
// An add, ACK or sweep command walks the table after the accepting edge: the
// sequencer scans every slot, drains the compare stage and then commits, and
// the result is loaded into the output register at commit. A data-received
// command skips the walk and goes from idle straight to commit. The next
// command is taken once the sequencer is back in idle. During the walk one
// slot of the entry memory is read per cycle and checked by the single shared
// 32-bit compare unit. The input is taken only while the sequencer is idle;
// the result sits in an output register, so a new command is taken while the
// last result waits, but its own result is not committed until that register
// is free.
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// ack_coordination_pending_table
// Pending packet table with deadlines: add, ACK match, timeout sweep and ACK
// generation, one result beat per command.
// ----------------------------------------------------------------------------
module ack_coordination_pending_table import acpt_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration: local_address
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [47:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [143:0] s_tdata,  // pkt_id, ack_sender, deadline, now_time
    input  logic [1:0]   s_tuser,  // command
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,  // msg_pkt_id, msg_destination, msg_ttl,
                                   // expired_count, 2 bits zero
    output logic [4:0]   m_tuser   // status, msg_kind
);

    logic [47:0] local_address_reg;
    logic        m_valid_reg;
    result_t     m_result_reg;
    item_t       in_item;
    result_t     res;
    logic        res_load;
    logic        out_free;
    logic        res_no_msg;
    logic        res_not_swept;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            local_address_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            local_address_reg <= cfg_data;
        end
    end

    always_comb begin
        in_item.command    = cmd_e_t'(s_tuser);
        in_item.pkt_id     = s_tdata[31:0];
        in_item.ack_sender = s_tdata[79:32];
        in_item.deadline   = s_tdata[111:80];
        in_item.now_time   = s_tdata[143:112];
    end

    assign out_free = !m_valid_reg || m_tready;

    acpt_ctrl #(
        .DEPTH(TABLE_DEPTH)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_item       (in_item),
        .local_address (local_address_reg),
        .out_free      (out_free),
        .res_load      (res_load),
        .res           (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            m_result_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_result_reg.expired_count, m_result_reg.msg_ttl,
                       m_result_reg.msg_destination, m_result_reg.msg_pkt_id};
    assign m_tuser  = {m_result_reg.msg_kind, m_result_reg.status};

    assign res_no_msg    = m_tvalid && (m_result_reg.msg_kind == MSG_NONE);
    assign res_not_swept = m_tvalid && (m_result_reg.status != ST_SWEPT);

    // one command in flight at a time
    `ACPT_ASSERT(a_one_in_flight, s_tvalid && s_tready |=> !s_tready, "beat taken while busy")
    // no message means empty message fields
    `ACPT_ASSERT(a_no_msg_empty, res_no_msg |-> m_tdata[80:0] == 81'd0, "stray message fields")
    // only the sweep reports a count
    `ACPT_ASSERT(a_count_sweep, res_not_swept |-> m_tdata[85:81] == 5'd0, "count outside a sweep")
    // a result is never loaded over one that is still waiting
    `ACPT_ASSERT_ALWAYS(a_no_overwrite, res_load |-> out_free, "result overwritten")

endmodule
